/* rtl/ncdf_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, fixed-point constants and types for the normal CDF unit.
// Used by every module of the block; depends on nothing.
package ncdf_pkg;

  localparam int XW = 16;
  localparam int PW = 16;
  localparam int QF = 30;
  localparam int AW = 17;
  localparam int DENW = 30;
  localparam int KW = 31;
  localparam int TW = 33;
  localparam int MW = 32;
  localparam int PMW = MW + KW;
  localparam int ROMW = 29;
  localparam int ROM_DEPTH = 2049;
  localparam int IDXW = 12;
  localparam int FRW = 4;
  localparam int STEPS = 5;

  localparam logic [63:0] ONE64 = 64'd1073741824;
  localparam logic [63:0] DEC_RND = 64'd500000000;
  localparam logic [63:0] DEC_SCALE = 64'd1000000000;
  localparam logic [63:0] HALF_Q30 = 64'd536870912;

  localparam logic [13:0] SLOPE_Q16 =
    14'((64'd231641900 * 64'd65536 + DEC_RND) / DEC_SCALE);
  localparam logic [31:0] INV_SQRT2PI =
    32'((64'd398942280 * ONE64 + DEC_RND) / DEC_SCALE);
  localparam logic [31:0] B1_MAG = 32'((64'd319381530 * ONE64 + DEC_RND) / DEC_SCALE);
  localparam logic [31:0] B2_MAG = 32'((64'd356563782 * ONE64 + DEC_RND) / DEC_SCALE);
  localparam logic [31:0] B3_MAG = 32'((64'd1781477937 * ONE64 + DEC_RND) / DEC_SCALE);
  localparam logic [31:0] B4_MAG = 32'((64'd1821255978 * ONE64 + DEC_RND) / DEC_SCALE);
  localparam logic [31:0] B5_MAG = 32'((64'd1330274429 * ONE64 + DEC_RND) / DEC_SCALE);

  localparam logic signed [TW-1:0] COEF_B1 = $signed({1'b0, B1_MAG});
  localparam logic signed [TW-1:0] COEF_B2 = -$signed({1'b0, B2_MAG});
  localparam logic signed [TW-1:0] COEF_B3 = $signed({1'b0, B3_MAG});
  localparam logic signed [TW-1:0] COEF_B4 = -$signed({1'b0, B4_MAG});
  localparam logic signed [TW-1:0] COEF_B5 = $signed({1'b0, B5_MAG});

  localparam logic [DENW-1:0] DEN_ONE = DENW'(64'd1 << 28);
  localparam logic [DENW-1:0] REM_INIT = DENW'(64'd1 << 27);
  localparam logic [IDXW-1:0] ROM_TOP = IDXW'(2048);
  localparam logic [QF:0] ONE_Q = (QF+1)'(ONE64);
  localparam logic [3:0] TAYLOR_TERMS = 4'd12;
  localparam logic [2:0] LAST_SQUARE = 3'd4;
  localparam logic [4:0] DIV_LAST = 5'(QF);

  typedef struct packed {
    logic            neg;
    logic [IDXW-1:0] idx;
    logic [FRW-1:0]  frac;
  } side_t;

  typedef struct packed {
    logic          neg;
    logic [KW-1:0] poly;
  } tag_t;

  function automatic logic signed [TW-1:0] horner_coef(input int unsigned step);
    case (step)
      0: return COEF_B4;
      1: return COEF_B3;
      2: return COEF_B2;
      3: return COEF_B1;
      default: return '0;
    endcase
  endfunction

endpackage

/* rtl/ncdf_recip.sv */
`timescale 1ns / 1ps
// Absolute value, denominator and pipelined restoring divider for k.
// One quotient bit per stage; depends on ncdf_pkg.
module ncdf_recip
  import ncdf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [XW-1:0] in_x,
  output logic                 out_vld,
  output logic [KW-1:0]        out_k,
  output side_t                out_side
);

  localparam int NS = KW;

  logic              neg;
  logic [AW-1:0]     mag;
  logic [AW+13:0]    slope_prod;
  logic [DENW-1:0]   den_nxt;
  side_t             side_nxt;
  logic [NS:0]       v_r;
  logic [DENW-1:0]   den_r [0:NS-1];
  logic [DENW-1:0]   rem_r [0:NS-1];
  logic [KW-1:0]     lo_r  [0:NS-1];
  logic [KW-1:0]     q_r   [0:NS];
  side_t             side_r [0:NS];

  assign neg        = in_x[XW-1];
  assign mag        = neg ? (AW'(17'h10000) - {1'b0, in_x}) : {1'b0, in_x};
  assign slope_prod = mag * SLOPE_Q16;
  assign den_nxt    = DEN_ONE + DENW'(slope_prod);
  assign side_nxt   = '{neg: neg, idx: IDXW'(mag >> FRW), frac: mag[FRW-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0]  <= den_nxt;
      rem_r[0]  <= REM_INIT;
      lo_r[0]   <= {2'b00, den_nxt[DENW-1:1]};
      q_r[0]    <= '0;
      side_r[0] <= side_nxt;
    end
  end

  for (genvar s = 1; s <= NS; s++) begin : g_div
    logic [DENW:0] trial;
    logic          ge;
    assign trial = {rem_r[s-1], lo_r[s-1][KW-1]};
    assign ge    = trial >= {1'b0, den_r[s-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s]    <= {q_r[s-1][KW-2:0], ge};
        side_r[s] <= side_r[s-1];
      end
    end

    if (s < NS) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= ge ? DENW'(trial - {1'b0, den_r[s-1]}) : DENW'(trial);
          lo_r[s]  <= {lo_r[s-1][KW-2:0], 1'b0};
          den_r[s] <= den_r[s-1];
        end
      end
    end
  end

  assign out_vld  = v_r[NS];
  assign out_k    = q_r[NS];
  assign out_side = side_r[NS];

endmodule

/* rtl/ncdf_horner.sv */
`timescale 1ns / 1ps
// Horner evaluation of the five-term polynomial in k, two stages per term.
// Depends on ncdf_pkg for coefficients and widths.
module ncdf_horner
  import ncdf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [KW-1:0] in_k,
  input  side_t         in_side,
  output logic          out_vld,
  output logic [KW-1:0] out_poly,
  output side_t         out_side
);

  logic [2*STEPS:0]        v_r;
  logic signed [TW-1:0]    t_r    [0:STEPS];
  logic [KW-1:0]           k_r    [0:STEPS-1];
  side_t                   side_r [0:STEPS];
  logic [PMW-1:0]          pm_r   [0:STEPS-1];
  logic                    sg_r   [0:STEPS-1];
  logic [KW-1:0]           km_r   [0:STEPS-2];
  side_t                   sm_r   [0:STEPS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2*STEPS-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0]    <= COEF_B5;
      k_r[0]    <= in_k;
      side_r[0] <= in_side;
    end
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [MW-1:0]        mag;
    logic [TW-1:0]        rnd;
    logic signed [TW-1:0] term;
    assign mag  = t_r[s][TW-1] ? MW'(-t_r[s]) : MW'(t_r[s]);
    assign rnd  = TW'((pm_r[s] + PMW'(HALF_Q30)) >> QF);
    assign term = sg_r[s] ? -$signed(rnd) : $signed(rnd);

    always_ff @(posedge clk) begin
      if (en) begin
        pm_r[s]     <= mag * k_r[s];
        sg_r[s]     <= t_r[s][TW-1];
        sm_r[s]     <= side_r[s];
        t_r[s+1]    <= horner_coef(s) + term;
        side_r[s+1] <= sm_r[s];
      end
    end

    if (s < STEPS-1) begin : g_k
      always_ff @(posedge clk) begin
        if (en) begin
          km_r[s]  <= k_r[s];
          k_r[s+1] <= km_r[s];
        end
      end
    end
  end

  assign out_vld  = v_r[2*STEPS];
  assign out_poly = t_r[STEPS][TW-1] ? '0 : KW'(t_r[STEPS]);
  assign out_side = side_r[STEPS];

endmodule

/* rtl/ncdf_dens.sv */
`timescale 1ns / 1ps
// Density table with its post-reset fill sequencer, two-port read and
// linear interpolation. Depends on ncdf_pkg.
module ncdf_dens
  import ncdf_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  side_t           in_side,
  input  logic [KW-1:0]   in_poly,
  output logic            out_vld,
  output logic [ROMW-1:0] out_dens,
  output tag_t            out_tag,
  output logic            fill_done
);

  typedef enum logic [3:0] {
    F_INIT, F_MUL, F_RND, F_DIV, F_UPD, F_SQM, F_SQR, F_CM, F_WR, F_DONE
  } fill_state_t;

  localparam int PRW = 62;

  fill_state_t       state_r;
  logic [IDXW-1:0]   g_r;
  logic [QF:0]       u_r;
  logic [QF:0]       r_r;
  logic [3:0]        n_r;
  logic [PRW-1:0]    prod_r;
  logic [QF:0]       d_r;
  logic [3:0]        drem_r;
  logic [4:0]        cnt_r;
  logic [2:0]        sq_r;
  logic [2*IDXW-1:0] gsq;
  logic [QF:0]       prod_rnd;
  logic [4:0]        trial;
  logic              ge;

  logic [ROMW-1:0]   mem [0:ROM_DEPTH-1];
  logic [IDXW-1:0]   idx_hi;
  logic [1:0]        v_r;
  logic [ROMW-1:0]   rd0_r;
  logic [ROMW-1:0]   rd1_r;
  logic [FRW-1:0]    frac_r;
  tag_t              tag0_r;
  tag_t              tag1_r;
  logic [ROMW-1:0]   dens_r;
  logic [ROMW+FRW:0] mix;

  assign gsq      = g_r * g_r;
  assign prod_rnd = (QF+1)'((prod_r + PRW'(HALF_Q30)) >> QF);
  assign trial    = {drem_r, d_r[QF]};
  assign ge       = trial >= {1'b0, n_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_INIT;
      g_r     <= '0;
    end else begin
      unique case (state_r)
        F_INIT: begin
          u_r     <= (QF+1)'({gsq, 8'd0});
          r_r     <= ONE_Q;
          n_r     <= TAYLOR_TERMS;
          state_r <= F_MUL;
        end
        F_MUL: begin
          prod_r  <= u_r * r_r;
          state_r <= F_RND;
        end
        F_RND: begin
          d_r     <= prod_rnd + (QF+1)'(n_r >> 1);
          drem_r  <= '0;
          cnt_r   <= '0;
          state_r <= F_DIV;
        end
        F_DIV: begin
          drem_r <= ge ? 4'(trial - {1'b0, n_r}) : 4'(trial);
          d_r    <= {d_r[QF-1:0], ge};
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == DIV_LAST) begin
            state_r <= F_UPD;
          end
        end
        F_UPD: begin
          r_r <= (d_r >= ONE_Q) ? '0 : ONE_Q - d_r;
          if (n_r == 4'd1) begin
            sq_r    <= '0;
            state_r <= F_SQM;
          end else begin
            n_r     <= n_r - 4'd1;
            state_r <= F_MUL;
          end
        end
        F_SQM: begin
          prod_r  <= r_r * r_r;
          state_r <= F_SQR;
        end
        F_SQR: begin
          r_r <= prod_rnd;
          if (sq_r == LAST_SQUARE) begin
            state_r <= F_CM;
          end else begin
            sq_r    <= sq_r + 3'd1;
            state_r <= F_SQM;
          end
        end
        F_CM: begin
          prod_r  <= r_r * INV_SQRT2PI;
          state_r <= F_WR;
        end
        F_WR: begin
          if (g_r == ROM_TOP) begin
            state_r <= F_DONE;
          end else begin
            g_r     <= g_r + IDXW'(1);
            state_r <= F_INIT;
          end
        end
        F_DONE: begin
          state_r <= F_DONE;
        end
        default: begin
          state_r <= F_INIT;
        end
      endcase
    end
  end

  assign fill_done = (state_r == F_DONE);

  always_ff @(posedge clk) begin
    if (state_r == F_WR) begin
      mem[g_r] <= ROMW'(prod_rnd);
    end
  end

  assign idx_hi = (in_side.idx < ROM_TOP) ? in_side.idx + IDXW'(1) : in_side.idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[0], in_vld};
    end
  end

  assign mix = rd0_r * ((ROMW+FRW+1)'(16) - (ROMW+FRW+1)'(frac_r))
             + rd1_r * (ROMW+FRW+1)'(frac_r) + (ROMW+FRW+1)'(8);

  always_ff @(posedge clk) begin
    if (en) begin
      rd0_r  <= mem[in_side.idx];
      rd1_r  <= mem[idx_hi];
      frac_r <= in_side.frac;
      tag0_r <= '{neg: in_side.neg, poly: in_poly};
      dens_r <= ROMW'(mix >> FRW);
      tag1_r <= tag0_r;
    end
  end

  assign out_vld  = v_r[1];
  assign out_dens = dens_r;
  assign out_tag  = tag1_r;

endmodule

/* rtl/normal_cdf_approximation.sv */
`timescale 1ns / 1ps
// Top level of the pipelined normal CDF unit (Abramowitz-Stegun 26.2.17).
// Instantiates ncdf_recip, ncdf_horner and ncdf_dens; depends on ncdf_pkg.
//
//   channel | ports                                 | carries
//   in      | in_valid, in_ready, in_x_value        | signed Q4.12 argument
//   out     | out_valid, out_ready, out_probability | unsigned Q0.16 probability
//
// One request is taken per cycle while in_ready is high.
// The path holds 47 registers: 32 in the reciprocal divider, 11 in the polynomial
// chain, two in the density lookup and two at the output.
// After reset the density table is computed in place; in_ready stays low until it is complete.
// A stalled output freezes every stage, so nothing is lost or repeated.
module normal_cdf_approximation
  import ncdf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [XW-1:0] in_x_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PW-1:0]        out_probability
);

  logic              en;
  logic              fill_done;
  logic              rv;
  logic [KW-1:0]     rk;
  side_t             rside;
  logic              hv;
  logic [KW-1:0]     hpoly;
  side_t             hside;
  logic              dv;
  logic [ROMW-1:0]   dens;
  tag_t              dtag;
  logic              tv_r;
  logic              tneg_r;
  logic [ROMW+KW-1:0] tprod_r;
  logic [QF:0]       tail_rnd;
  logic [QF:0]       tail;
  logic [QF:0]       pval;
  logic [QF-13:0]    scaled;
  logic              out_valid_r;
  logic [PW-1:0]     out_probability_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en && fill_done;

  ncdf_recip u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid && in_ready),
    .in_x     (in_x_value),
    .out_vld  (rv),
    .out_k    (rk),
    .out_side (rside)
  );

  ncdf_horner u_horner (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (rv),
    .in_k     (rk),
    .in_side  (rside),
    .out_vld  (hv),
    .out_poly (hpoly),
    .out_side (hside)
  );

  ncdf_dens u_dens (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (hv),
    .in_side   (hside),
    .in_poly   (hpoly),
    .out_vld   (dv),
    .out_dens  (dens),
    .out_tag   (dtag),
    .fill_done (fill_done)
  );

  assign tail_rnd = (QF+1)'((tprod_r + (ROMW+KW)'(HALF_Q30)) >> QF);
  assign tail     = (tail_rnd > ONE_Q) ? ONE_Q : tail_rnd;
  assign pval     = tneg_r ? tail : ONE_Q - tail;
  assign scaled   = (QF-12)'(({1'b0, pval} + (QF+2)'(14'h2000)) >> 14);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      tv_r        <= dv;
      out_valid_r <= tv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tprod_r           <= dens * dtag.poly;
      tneg_r            <= dtag.neg;
      out_probability_r <= scaled[QF-13:PW] != '0 ? {PW{1'b1}} : scaled[PW-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_probability = out_probability_r;

  a_no_result_before_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !fill_done |-> !out_valid)
    else $error("result issued before density table fill completed");

  a_fill_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fill_done |=> fill_done)
    else $error("density table fill status dropped");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({hv, dv, tv_r, out_valid_r}))
    else $error("pipeline moved during an output stall");

endmodule

/* verif/tb_normal_cdf_approximation.sv */
`timescale 1ns / 1ps
// Self-checking testbench for normal_cdf_approximation, the pipelined normal CDF unit.
// Builds its own fixed-point CDF predictor and drives both valid/ready channels
// with random gaps. Depends on ncdf_pkg and the RTL of the block.

class cdf_scoreboard;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned HALF_Q30 = 64'd1 << 29;

  longint unsigned density_rom[0:2048];
  longint coef[5];
  longint unsigned slope_q16;
  longint unsigned inv_sqrt2pi;
  logic [15:0] expected_probability[$];
  int errors;

  function automatic longint unsigned q30_of(longint unsigned n);
    return (n * ONE_Q30 + 64'd500000000) / 64'd1000000000;
  endfunction

  function automatic longint unsigned density_sample(int unsigned g);
    longint unsigned u, r, term;
    u = (longint'(g) * longint'(g)) << 8;
    r = ONE_Q30;
    for (int n = 12; n >= 1; n--) begin
      term = (u * r + HALF_Q30) >> 30;
      term = (term + n / 2) / n;
      r = (term >= ONE_Q30) ? 0 : ONE_Q30 - term;
    end
    for (int s = 0; s < 5; s++) r = (r * r + HALF_Q30) >> 30;
    return (r * inv_sqrt2pi + HALF_Q30) >> 30;
  endfunction

  function new();
    slope_q16 = (64'd231641900 * 64'd65536 + 64'd500000000) / 64'd1000000000;
    inv_sqrt2pi = q30_of(64'd398942280);
    coef[0] = q30_of(64'd319381530);
    coef[1] = -longint'(q30_of(64'd356563782));
    coef[2] = q30_of(64'd1781477937);
    coef[3] = -longint'(q30_of(64'd1821255978));
    coef[4] = q30_of(64'd1330274429);
    for (int g = 0; g <= 2048; g++) density_rom[g] = density_sample(g);
    errors = 0;
  endfunction

  function automatic longint scale_by_k(longint s, longint unsigned k);
    longint unsigned m, p;
    m = (s < 0) ? longint'(-s) : s;
    p = (m * k + HALF_Q30) >> 30;
    return (s < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [15:0] predict_probability(logic signed [15:0] x);
    logic neg;
    longint unsigned mag, den, k, dens, poly, tail, v;
    longint t;
    int unsigned i, j, f;
    neg = x[15];
    mag = neg ? (64'h10000 - {48'd0, x}) : {48'd0, x};
    den = (64'd1 << 28) + mag * slope_q16;
    k = ((64'd1 << 58) + den / 2) / den;
    i = 32'(mag >> 4);
    f = 32'(mag & 15);
    j = (i < 2048) ? i + 1 : i;
    t = coef[4];
    for (int c = 3; c >= 0; c--) t = coef[c] + scale_by_k(t, k);
    t = scale_by_k(t, k);
    poly = (t < 0) ? 0 : t;
    dens = (density_rom[i] * (16 - f) + density_rom[j] * f + 8) >> 4;
    tail = (dens * poly + HALF_Q30) >> 30;
    if (tail > ONE_Q30) tail = ONE_Q30;
    v = neg ? tail : ONE_Q30 - tail;
    v = (v + (64'd1 << 13)) >> 14;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function void note_request(logic signed [15:0] x);
    expected_probability.push_back(predict_probability(x));
  endfunction

  function void check_result(logic [15:0] probability);
    logic [15:0] want;
    if (expected_probability.size() == 0) begin
      $error("probability: unexpected result %0d", probability);
      errors++;
      return;
    end
    want = expected_probability.pop_front();
    if (want !== probability) begin
      $error("probability: expected %0d actual %0d", want, probability);
      errors++;
    end
  endfunction

  function int pending();
    return expected_probability.size();
  endfunction
endclass

module tb_normal_cdf_approximation;
  import ncdf_pkg::*;

  localparam int RANDOM_REQUESTS = 930;
  localparam int IDLE_LIMIT = 4000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [XW-1:0] in_x_value;
  logic out_valid;
  logic out_ready;
  logic [PW-1:0] out_probability;

  cdf_scoreboard cdf_board;
  int requests_sent;
  int idle_cycles;

  normal_cdf_approximation dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_x_value(in_x_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_probability(out_probability)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_argument();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom);
    if (r < 90) return 16'($signed($urandom_range(0, 40960)) - 20480);
    return 16'($signed($urandom_range(0, 64)) - 32);
  endfunction

  task automatic send_request(logic [15:0] x, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_value <= x;
    do @(posedge clk); while (!in_ready);
    cdf_board.note_request(x);
    requests_sent++;
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) cdf_board.check_result(out_probability);
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && requests_sent >= 300) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [15:0] directed[$];
    directed = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
                 16'h000F, 16'h0010, 16'h0011, 16'hFFF0, 16'h1000, 16'hF000,
                 16'h2000, 16'hE000, 16'h4000, 16'hC000, 16'h5555, 16'hAAAA,
                 16'h6000, 16'hA000, 16'h7FF0, 16'h8010, 16'h0FFF, 16'hF001};
    cdf_board = new();
    requests_sent = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x_value = '0;
    out_ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[n]) send_request(directed[n], (n % 3 == 0) ? 0 : pick_gap());
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 600) begin
        in_valid <= 1'b0;
        while (cdf_board.pending() != 0) @(posedge clk);
      end
      send_request(pick_argument(), (n >= 100 && n < 160) ? 0 : pick_gap());
    end
    in_valid <= 1'b0;
    while (cdf_board.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (cdf_board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
